[rtl/iefa_pkg.sv]
// Package for the IMU event frame assembler: beat types, register map,
// frame slot constants and the fixed-point scale tables.
// Self-contained; imported by imu_event_frame_assembler.
`timescale 1ns / 1ps
`default_nettype none

package iefa_pkg;

    // Frame layout.
    localparam int FRAME_SLOTS = 9;
    localparam int AXIS_SLOTS  = 6;
    localparam int FRAC_BITS   = 16;

    localparam logic [3:0] SLOT_FIRST    = 4'd0;
    localparam logic [3:0] SLOT_STAMP_HI = 4'(AXIS_SLOTS);
    localparam logic [3:0] SLOT_STAMP_LO = 4'(AXIS_SLOTS + 1);
    localparam logic [3:0] SLOT_COUNT    = 4'(FRAME_SLOTS - 1);

    // Axis slots whose value is negated on top of its own sign.
    localparam logic [2:0] SLOT_ACCEL_X = 3'd0;
    localparam logic [2:0] SLOT_RATE_X  = 3'd3;

    // Register map, indexed by paddr[3:2].
    localparam int          ADDR_W          = 4;
    localparam logic [1:0] REG_ACCEL_RANGE = 2'd0;
    localparam logic [1:0] REG_GYRO_RANGE  = 2'd1;
    localparam logic [1:0] REG_GROUP_DELAY = 2'd2;

    localparam logic [1:0]  ACCEL_CODE_RESET = 2'd3;
    localparam logic [2:0]  GYRO_CODE_RESET  = 3'd0;
    localparam logic [2:0]  GYRO_CODE_MAX    = 3'd4;

    // Scaling: magnitude = (m * Q + 2^(S-1)) >> S with Q = ceil(K * 2^S),
    // K being the exact per-LSB factor. S = 70 - FRAC_BITS keeps every Q
    // within 64 bits and the rounding error below the spacing of the
    // exact quotients, so the result equals the round-half-up quotient.
    localparam int          SCALE_SHIFT = 70 - FRAC_BITS;
    localparam int          PROD_W      = 80;
    localparam logic [PROD_W-1:0] SCALE_ROUND = PROD_W'(1) << (SCALE_SHIFT - 1);

    // Accelerometer: K = 9.80665 * g * 2^F / 32768, g = 3 << code.
    localparam logic [127:0] ACC_DEN = 128'd100000;
    localparam logic [127:0] ACC_NUM = 128'd980665 << 55;
    localparam logic [63:0] ACC_Q0 = 64'((ACC_NUM * 128'd3 + ACC_DEN - 128'd1) / ACC_DEN);
    localparam logic [63:0] ACC_Q1 = 64'((ACC_NUM * 128'd6 + ACC_DEN - 128'd1) / ACC_DEN);
    localparam logic [63:0] ACC_Q2 = 64'((ACC_NUM * 128'd12 + ACC_DEN - 128'd1) / ACC_DEN);
    localparam logic [63:0] ACC_Q3 = 64'((ACC_NUM * 128'd24 + ACC_DEN - 128'd1) / ACC_DEN);

    // Gyroscope: K = dps * pi * 2^F / (180 * (32768 + c)), pi with 36
    // fraction bits, dps = 2000 >> c.
    localparam logic [127:0] PI_Q36  = 128'h3243F6A888;
    localparam logic [127:0] GYR_NUM = PI_Q36 << 34;
    localparam logic [127:0] GYR_D0  = 128'd180 * 128'd32768;
    localparam logic [127:0] GYR_D1  = 128'd180 * 128'd32769;
    localparam logic [127:0] GYR_D2  = 128'd180 * 128'd32770;
    localparam logic [127:0] GYR_D3  = 128'd180 * 128'd32771;
    localparam logic [127:0] GYR_D4  = 128'd180 * 128'd32772;
    localparam logic [63:0] GYR_Q0 = 64'((GYR_NUM * 128'd2000 + GYR_D0 - 128'd1) / GYR_D0);
    localparam logic [63:0] GYR_Q1 = 64'((GYR_NUM * 128'd1000 + GYR_D1 - 128'd1) / GYR_D1);
    localparam logic [63:0] GYR_Q2 = 64'((GYR_NUM * 128'd500 + GYR_D2 - 128'd1) / GYR_D2);
    localparam logic [63:0] GYR_Q3 = 64'((GYR_NUM * 128'd250 + GYR_D3 - 128'd1) / GYR_D3);
    localparam logic [63:0] GYR_Q4 = 64'((GYR_NUM * 128'd125 + GYR_D4 - 128'd1) / GYR_D4);

    // Input beat.
    typedef struct packed {
        logic               is_sync;
        logic signed [31:0] event_value;
    } evt_t;

    // Output beat: one assembled frame.
    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic [63:0]        stamp;
        logic [31:0]        sample_count;
        logic               count_gap;
        logic [31:0]        lost_frames;
    } rec_t;

    // Scale pipeline, first stage: operands of the multiply.
    typedef struct packed {
        logic [2:0]  slot;
        logic        negative;
        logic [15:0] mag_in;
        logic [63:0] factor;
    } scale_op_t;

    // Scale pipeline, second stage: partial products.
    typedef struct packed {
        logic [2:0]  slot;
        logic        negative;
        logic [47:0] prod_hi;
        logic [47:0] prod_lo;
    } scale_prod_t;

    // Scale factor for an accelerometer range code.
    function automatic logic [63:0] accel_factor(input logic [1:0] code);
        logic [63:0] q;
        case (code)
            2'd0:    q = ACC_Q0;
            2'd1:    q = ACC_Q1;
            2'd2:    q = ACC_Q2;
            2'd3:    q = ACC_Q3;
            default: q = ACC_Q3;
        endcase
        return q;
    endfunction

    // Scale factor for a gyro range code; codes above four act as four.
    function automatic logic [63:0] gyro_factor(input logic [2:0] code);
        logic [63:0] q;
        case (code)
            3'd0:    q = GYR_Q0;
            3'd1:    q = GYR_Q1;
            3'd2:    q = GYR_Q2;
            3'd3:    q = GYR_Q3;
            default: q = GYR_Q4;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

[rtl/imu_event_frame_assembler.sv]
// IMU event frame assembler: collects nine data beats into one frame record,
// scaling the six axis values to fixed point on the way in.
// Depends on iefa_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel | signals                          | beat
//  --------+----------------------------------+------------------------------
//  events  | evt_valid, evt_ready, evt        | sync marker or data value
//  records | rec_valid, rec_ready, rec        | one assembled frame
//  config  | psel, penable, pwrite, paddr,    | range codes, group delay
//          | pwdata, prdata, pready           |
//
// One event beat is taken per cycle. An axis value passes a three-stage
// scale pipeline (factor select, two 16x32 partial products, round and
// saturate) and lands in the axis store by way of s0_reg and s1_reg.
// The record register loads on the edge that takes the count beat.
// Reset returns the slot counter, counters and range registers to defaults.
// Events stall only while the frame sits on its count slot and the previous
// record is still waiting; any beat, sync or data, waits in that cycle.

module imu_event_frame_assembler
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               evt_valid,
    output logic              evt_ready,
    input  wire iefa_pkg::evt_t evt,
    output logic              rec_valid,
    input  wire               rec_ready,
    output iefa_pkg::rec_t    rec,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [iefa_pkg::ADDR_W-1:0] paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import iefa_pkg::*;

    // Configuration registers.
    logic [1:0]  accel_code_reg;
    logic [2:0]  gyro_code_reg;
    logic [30:0] group_delay_reg;

    // Frame state.
    logic [3:0]  slot_index_reg;
    logic [3:0]  slot_index_next;
    logic [31:0] axis_store_reg [AXIS_SLOTS];
    logic [31:0] stamp_high_reg;
    logic [31:0] stamp_low_reg;
    logic [31:0] previous_count_reg;
    logic [31:0] previous_count_next;
    logic [31:0] lost_total_reg;
    logic [31:0] lost_total_next;

    // Scale pipeline.
    logic        s0_valid_reg;
    logic        s0_valid_next;
    scale_op_t   s0_reg;
    scale_op_t   s0_next;
    logic        s1_valid_reg;
    scale_prod_t s1_reg;
    logic [PROD_W-1:0] scaled_sum;
    logic [PROD_W-1:0] scaled_mag;
    logic [31:0]       scaled_value;

    // Output register.
    logic        rec_valid_reg;
    logic        rec_valid_next;
    rec_t        rec_reg;
    rec_t        rec_next;

    // Beat decode.
    logic        evt_fire;
    logic        data_fire;
    logic        sync_fire;
    logic        count_fire;
    logic        cfg_write;
    logic [15:0] low_bits;
    logic        low_negative;
    logic [2:0]  axis_slot;
    logic        axis_flip;

    assign pready    = 1'b1;
    assign evt_ready = !(slot_index_reg == SLOT_COUNT && rec_valid_reg && !rec_ready);
    assign evt_fire  = evt_valid && evt_ready;
    assign data_fire = evt_fire && !evt.is_sync;
    assign sync_fire = evt_fire && evt.is_sync;
    assign count_fire = data_fire && (slot_index_reg == SLOT_COUNT);
    assign cfg_write = psel && penable && pwrite && pready;

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_code_reg  <= ACCEL_CODE_RESET;
            gyro_code_reg   <= GYRO_CODE_RESET;
            group_delay_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ACCEL_RANGE: accel_code_reg  <= pwdata[1:0];
                REG_GYRO_RANGE:  gyro_code_reg   <= pwdata[2:0];
                REG_GROUP_DELAY: group_delay_reg <= pwdata[30:0];
                default:         ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (paddr[3:2])
            REG_ACCEL_RANGE: prdata = {30'd0, accel_code_reg};
            REG_GYRO_RANGE:  prdata = {29'd0, gyro_code_reg};
            REG_GROUP_DELAY: prdata = {1'b0, group_delay_reg};
            default:         prdata = '0;
        endcase
    end

    // First scale stage: magnitude of the low half-word, sign and factor.
    always_comb
    begin
        low_bits     = evt.event_value[15:0];
        low_negative = low_bits[15];
        axis_slot    = slot_index_reg[2:0];
        axis_flip    = (axis_slot == SLOT_ACCEL_X) || (axis_slot == SLOT_RATE_X);

        s0_valid_next   = data_fire && (slot_index_reg < SLOT_STAMP_HI);
        s0_next.slot    = axis_slot;
        s0_next.negative = low_negative ^ axis_flip;
        s0_next.mag_in  = low_negative ? (~low_bits + 16'd1) : low_bits;
        if (slot_index_reg < 4'(SLOT_RATE_X))
        begin
            s0_next.factor = accel_factor(accel_code_reg);
        end
        else
        begin
            s0_next.factor = gyro_factor(gyro_code_reg);
        end
    end

    // Scale pipeline registers; the pipeline never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg          <= s0_next;
        s1_reg.slot     <= s0_reg.slot;
        s1_reg.negative <= s0_reg.negative;
        s1_reg.prod_hi  <= 48'(s0_reg.mag_in) * 48'(s0_reg.factor[63:32]);
        s1_reg.prod_lo  <= 48'(s0_reg.mag_in) * 48'(s0_reg.factor[31:0]);
    end

    // Last scale stage: sum the partial products, round, saturate, sign.
    always_comb
    begin
        scaled_sum = {s1_reg.prod_hi, 32'd0} + PROD_W'(s1_reg.prod_lo) + SCALE_ROUND;
        scaled_mag = scaled_sum >> SCALE_SHIFT;
        if (s1_reg.negative)
        begin
            if (scaled_mag > PROD_W'(32'h8000_0000))
            begin
                scaled_value = 32'h8000_0000;
            end
            else
            begin
                scaled_value = 32'd0 - scaled_mag[31:0];
            end
        end
        else
        begin
            if (scaled_mag > PROD_W'(32'h7FFF_FFFF))
            begin
                scaled_value = 32'h7FFF_FFFF;
            end
            else
            begin
                scaled_value = scaled_mag[31:0];
            end
        end
    end

    // Axis store and timestamp words.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            axis_store_reg[s1_reg.slot] <= scaled_value;
        end
        if (data_fire && slot_index_reg == SLOT_STAMP_HI)
        begin
            stamp_high_reg <= evt.event_value;
        end
        if (data_fire && slot_index_reg == SLOT_STAMP_LO)
        begin
            stamp_low_reg <= evt.event_value;
        end
    end

    // Slot counter, count history and lost-frame counter.
    always_comb
    begin
        slot_index_next     = slot_index_reg;
        previous_count_next = previous_count_reg;
        lost_total_next     = lost_total_reg;
        if (sync_fire && slot_index_reg != SLOT_FIRST)
        begin
            slot_index_next = SLOT_FIRST;
            if (lost_total_reg != 32'hFFFF_FFFF)
            begin
                lost_total_next = lost_total_reg + 32'd1;
            end
        end
        else if (count_fire)
        begin
            slot_index_next     = SLOT_FIRST;
            previous_count_next = evt.event_value;
        end
        else if (data_fire)
        begin
            slot_index_next = slot_index_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg     <= SLOT_FIRST;
            previous_count_reg <= '0;
            lost_total_reg     <= '0;
        end
        else
        begin
            slot_index_reg     <= slot_index_next;
            previous_count_reg <= previous_count_next;
            lost_total_reg     <= lost_total_next;
        end
    end

    // Record assembly on the count beat.
    always_comb
    begin
        rec_next.accel_x      = axis_store_reg[0];
        rec_next.accel_y      = axis_store_reg[1];
        rec_next.accel_z      = axis_store_reg[2];
        rec_next.rate_x       = axis_store_reg[3];
        rec_next.rate_y       = axis_store_reg[4];
        rec_next.rate_z       = axis_store_reg[5];
        rec_next.stamp        = {stamp_high_reg, stamp_low_reg} - 64'(group_delay_reg);
        rec_next.sample_count = evt.event_value;
        rec_next.count_gap    = (previous_count_reg != 32'd0)
                             && (evt.event_value != previous_count_reg + 32'd1);
        rec_next.lost_frames  = lost_total_reg;

        if (count_fire)
        begin
            rec_valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            rec_valid_next = 1'b0;
        end
        else
        begin
            rec_valid_next = rec_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_fire)
        begin
            rec_reg <= rec_next;
        end
    end

`ifndef ASSERT_OFF
    // The slot counter never runs past the count slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_index_reg <= SLOT_COUNT)
        else $error("slot counter out of range");

    // No scaled axis is still in flight when the frame is read out.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_fire |-> (!s0_valid_reg && !s1_valid_reg))
        else $error("axis store read before scaling finished");

    // A count beat always presents a record on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_fire |=> rec_valid_reg)
        else $error("count beat produced no record");

    // A sync marker always empties the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        sync_fire |=> (slot_index_reg == SLOT_FIRST))
        else $error("sync marker left a partial frame");

    // The lost-frame counter never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        lost_total_reg >= $past(lost_total_reg))
        else $error("lost-frame counter decreased");
`endif

endmodule

`default_nettype wire

[test/imu_event_frame_assembler_tb.sv]
// Self-checking testbench for imu_event_frame_assembler: event beats in, frame records out.
// A built-in frame predictor checks every record; range codes and group delay go in by APB.
// Depends on iefa_pkg and the block's RTL.
`timescale 1ns / 1ps

module imu_event_frame_assembler_tb;

    import iefa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_WAIT  = 8;
    localparam int unsigned PHASE_ITEMS  = 170;
    localparam logic [127:0] GYRO_PI     = 128'h3243F6A888;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              evt_valid   = 1'b0;
    logic              evt_ready;
    evt_t              evt         = '0;
    logic              rec_valid;
    logic              rec_ready   = 1'b0;
    rec_t              rec;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor copy of the block's registers and frame state.
    logic [1:0]  accel_code    = ACCEL_CODE_RESET;
    logic [2:0]  gyro_code     = GYRO_CODE_RESET;
    logic [30:0] delay_val     = '0;
    logic [3:0]  slot_ptr      = SLOT_FIRST;
    logic [31:0] axis_words [AXIS_SLOTS];
    logic [31:0] stamp_hi_word = '0;
    logic [31:0] stamp_lo_word = '0;
    logic [31:0] prior_count   = '0;
    logic [31:0] lost_count    = '0;

    rec_t        pending_frames [$];
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;

    imu_event_frame_assembler dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random back-pressure on the record channel.
    always @(negedge clk)
    begin
        rec_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Scale one axis word to fixed point with the current range codes.
    function automatic logic [31:0] scaled_axis(input logic [2:0] slot, input logic [31:0] raw);
        logic [15:0]  v16;
        logic         neg;
        logic         flip;
        logic [2:0]   c;
        logic [127:0] m;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] mag;
        v16 = raw[15:0];
        neg = v16[15];
        m = neg ? (128'h10000 - 128'(v16)) : 128'(v16);
        if (slot < 3'd3)
        begin
            num = (m * 128'd980665 * (128'd3 << accel_code)) << FRAC_BITS;
            den = 128'd100000 << 15;
        end
        else
        begin
            c = (gyro_code > GYRO_CODE_MAX) ? GYRO_CODE_MAX : gyro_code;
            num = m * (128'd2000 >> c) * GYRO_PI;
            den = (128'd180 * (128'd32768 + 128'(c))) << (36 - FRAC_BITS);
        end
        mag = (num + den / 2) / den;
        flip = (slot == SLOT_ACCEL_X) || (slot == SLOT_RATE_X);
        // Round-half-away magnitude, then sign and saturate.
        if (neg != flip)
        begin
            if (mag > 128'h8000_0000)
                mag = 128'h8000_0000;
            return 32'd0 - mag[31:0];
        end
        if (mag > 128'h7FFF_FFFF)
            mag = 128'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // Advance the frame predictor by one accepted event beat.
    function automatic void predict_event(input evt_t beat);
        rec_t        frame;
        logic [31:0] count;
        if (beat.is_sync)
        begin
            // A sync on a partial frame drops it and counts it as lost.
            if (slot_ptr != SLOT_FIRST)
            begin
                if (lost_count != 32'hFFFF_FFFF)
                    lost_count++;
                slot_ptr = SLOT_FIRST;
            end
        end
        else if (slot_ptr < 4'(AXIS_SLOTS))
        begin
            axis_words[slot_ptr] = scaled_axis(slot_ptr[2:0], beat.event_value);
            slot_ptr++;
        end
        else if (slot_ptr == SLOT_STAMP_HI)
        begin
            stamp_hi_word = beat.event_value;
            slot_ptr++;
        end
        else if (slot_ptr == SLOT_STAMP_LO)
        begin
            stamp_lo_word = beat.event_value;
            slot_ptr++;
        end
        else
        begin
            // Count slot closes the frame.
            count = beat.event_value;
            frame.accel_x      = axis_words[0];
            frame.accel_y      = axis_words[1];
            frame.accel_z      = axis_words[2];
            frame.rate_x       = axis_words[3];
            frame.rate_y       = axis_words[4];
            frame.rate_z       = axis_words[5];
            frame.stamp        = {stamp_hi_word, stamp_lo_word} - 64'(delay_val);
            frame.sample_count = count;
            frame.count_gap    = (prior_count != 32'd0) && (count != prior_count + 32'd1);
            frame.lost_frames  = lost_count;
            pending_frames.push_back(frame);
            prior_count = count;
            slot_ptr = SLOT_FIRST;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every record beat with the oldest predicted frame.
    always @(posedge clk)
    begin
        rec_t want;
        if (rst_n && rec_valid && rec_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("record beat with no frame pending");
                fail_count++;
            end
            else
            begin
                want = pending_frames[0];
                pending_frames.delete(0);
                check_field("accel_x", 64'(want.accel_x), 64'(rec.accel_x));
                check_field("accel_y", 64'(want.accel_y), 64'(rec.accel_y));
                check_field("accel_z", 64'(want.accel_z), 64'(rec.accel_z));
                check_field("rate_x", 64'(want.rate_x), 64'(rec.rate_x));
                check_field("rate_y", 64'(want.rate_y), 64'(rec.rate_y));
                check_field("rate_z", 64'(want.rate_z), 64'(rec.rate_z));
                check_field("stamp", want.stamp, rec.stamp);
                check_field("sample_count", 64'(want.sample_count), 64'(rec.sample_count));
                check_field("count_gap", 64'(want.count_gap), 64'(rec.count_gap));
                check_field("lost_frames", 64'(want.lost_frames), 64'(rec.lost_frames));
            end
        end
    end

    // Send one event beat; called and returning at a falling edge.
    task automatic send_event(input logic sync, input logic [31:0] value);
        evt_t beat;
        beat.is_sync     = sync;
        beat.event_value = value;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= beat;
        @(posedge clk);
        while (!evt_ready)
            @(posedge clk);
        predict_event(beat);
        @(negedge clk);
    endtask

    // APB write: setup cycle, access cycle, then the bus returns to idle.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (index)
            REG_ACCEL_RANGE: accel_code = value[1:0];
            REG_GYRO_RANGE:  gyro_code  = value[2:0];
            REG_GROUP_DELAY: delay_val  = value[30:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted record has come out.
    task automatic drain_frames();
        evt_valid <= 1'b0;
        @(negedge clk);
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic set_ranges(input logic [1:0] acode, input logic [2:0] gcode,
                              input logic [30:0] delay);
        write_reg(REG_ACCEL_RANGE, 32'(acode));
        write_reg(REG_GYRO_RANGE, 32'(gcode));
        write_reg(REG_GROUP_DELAY, 32'(delay));
    endtask

    // Axis word: random, or an extreme low half under random upper bits.
    function automatic logic [31:0] random_axis_word();
        logic [15:0] low_half;
        if ($urandom_range(3) != 0)
            return $urandom();
        case ($urandom_range(4))
            0:       low_half = 16'h7FFF;
            1:       low_half = 16'h8000;
            2:       low_half = 16'hFFFF;
            3:       low_half = 16'h0001;
            default: low_half = 16'h0000;
        endcase
        return {16'($urandom()), low_half};
    endfunction

    function automatic logic [31:0] next_count();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return prior_count + 32'd1;
        if (pick < 80)
            return $urandom();
        if (pick < 90)
            return 32'd0;
        return 32'hFFFF_FFFF;
    endfunction

    // Send the first beats of a frame; a short frame is cut by a sync beat.
    task automatic send_frame(input int unsigned beats, inout int unsigned sent);
        logic [31:0] value;
        for (int unsigned i = 0; i < beats; i++)
        begin
            if (i < AXIS_SLOTS)
                value = random_axis_word();
            else if (i == SLOT_STAMP_HI)
                value = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
            else if (i == SLOT_STAMP_LO)
                value = $urandom();
            else
                value = next_count();
            send_event(1'b0, value);
            sent++;
        end
        if (beats < FRAME_SLOTS)
        begin
            send_event(1'b1, $urandom());
            sent++;
        end
    endtask

    // Reset ranges: axis extremes, upper bits set, all-ones stamp and count.
    task automatic test_reset_frame();
        send_event(1'b0, 32'h0000_7FFF);
        send_event(1'b0, 32'hFFFF_8000);
        send_event(1'b0, 32'hABCD_0000);
        send_event(1'b0, 32'h1234_8000);
        send_event(1'b0, 32'h8000_7FFF);
        send_event(1'b0, 32'hFFFF_FFFF);
        send_event(1'b0, 32'hFFFF_FFFF);
        send_event(1'b0, 32'hFFFF_FFFF);
        send_event(1'b0, 32'hFFFF_FFFF);
    endtask

    // Sync on an empty frame is ignored; sync mid-frame counts a lost frame.
    task automatic test_sync_markers();
        send_event(1'b1, 32'hFFFF_FFFF);
        send_event(1'b0, 32'h8000_0000);
        send_event(1'b0, 32'h0000_0001);
        send_event(1'b0, 32'h7FFF_FFFF);
        send_event(1'b1, 32'h0000_0000);
    endtask

    // Largest group delay on a small stamp wraps; count wraps to zero.
    task automatic test_stamp_wrap();
        drain_frames();
        set_ranges(2'd0, GYRO_CODE_MAX, 31'h7FFF_FFFF);
        send_event(1'b0, 32'h0000_8000);
        send_event(1'b0, 32'h0000_7FFF);
        send_event(1'b0, 32'h5555_0001);
        send_event(1'b0, 32'h0000_8000);
        send_event(1'b0, 32'hAAAA_7FFF);
        send_event(1'b0, 32'h0000_FFFF);
        send_event(1'b0, 32'h0000_0000);
        send_event(1'b0, 32'h0000_0010);
        send_event(1'b0, 32'h0000_0000);
    endtask

    // Random frames across range settings and idle modes.
    task automatic test_random_phases();
        int unsigned sent;
        int unsigned pick;
        logic [30:0] delay;
        for (int unsigned p = 0; p < 8; p++)
        begin
            drain_frames();
            case (p)
                0:       delay = '0;
                1:       delay = 31'h7FFF_FFFF;
                2:       delay = 31'd1;
                default: delay = 31'($urandom());
            endcase
            set_ranges(2'(p), 3'(p), delay);
            case (p % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 61; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    send_event(1'b1, $urandom());
                else if (pick < 18)
                    send_frame($urandom_range(1, FRAME_SLOTS - 1), sent);
                else
                    send_frame(FRAME_SLOTS, sent);
            end
        end
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_frame();
        test_sync_markers();
        test_stamp_wrap();
        test_random_phases();
        drain_frames();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[imu_event_frame_assembler.f]
rtl/iefa_pkg.sv
rtl/imu_event_frame_assembler.sv
test/imu_event_frame_assembler_tb.sv
